### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the queue depth, field widths, opcode and status codes, and the
// entry and control structs that the cells share.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;                       // entries held (2..31)
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);      // cell index width
  localparam int CNT_W       = 5;                        // fill_count field width
  localparam int VAL_W       = 32;
  localparam int PRI_W       = 16;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // Request kinds
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] priority_v;
  } entry_t;

  // Broadcast to every cell for one transaction
  typedef struct packed {
    logic   enq;    // insert item in sorted position
    logic   deq;    // shift everything one place toward the head
    entry_t item;   // entry being inserted
  } cell_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                  clk,
  input  spq_pkg::cell_ctrl_t   ctrl,
  input  logic                  occ,          // slot holds a live entry
  input  logic                  left_keep,    // left neighbor stays in place
  input  spq_pkg::entry_t       left_entry,
  input  spq_pkg::entry_t       right_entry,
  output spq_pkg::entry_t       entry,
  output logic                  keep
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Live entry at or below the new priority stays ahead of it (ties FIFO)
  assign keep = occ && (entry_r.priority_v <= ctrl.item.priority_v);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.deq) begin
      entry_nxt = right_entry;
    end else if (ctrl.enq && !keep) begin
      if (left_keep) begin
        entry_nxt = ctrl.item;
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### hw/rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded min-first priority queue
// A row of cells keeps the entries sorted by ascending priority; the head
// cell always holds the entry that leaves next.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel: in_tuser is the opcode (enqueue or
//   dequeue), in_tdata carries the item and its priority. Every request
//   gives exactly one result transaction on the out_ channel with a status,
//   the dequeued entry (zero otherwise) and the fill count afterwards.
//   The result is registered and valid the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken. All cells
//   compare against the new priority and shift in the same cycle, so the
//   cell row update sets the rate; a request waits only on a held result.
//   Ties leave in arrival order. An enqueue to a full queue reports
//   overflow, a dequeue from an empty queue reports underflow; neither
//   changes the contents.
//   Reset empties the queue (count cleared) and drops any pending result.
//   When the receiver stalls, the result is held in the output register;
//   in_tready drops until it is taken, so no request is lost.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [31:0] item_value, [47:32] item_priority
  input  logic [0:0]  in_tuser,    // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [31:0] out_value, [47:32] out_priority,
                                   // [52:48] fill_count, [55:53] zero
  output logic [1:0]  out_tuser    // [1:0] status
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  logic                       in_acc;
  logic                       is_deq;
  logic                       full;
  logic                       empty;
  spq_pkg::cell_ctrl_t        ctrl;
  spq_pkg::entry_t            cell_entry [N];
  logic [N-1:0]               cell_keep;
  logic [N-1:0]               cell_occ;

  logic [spq_pkg::CNT_W-1:0]  count_r;
  logic [spq_pkg::CNT_W-1:0]  count_nxt;
  logic                       out_valid_r;
  logic [1:0]                 status_r;
  logic [1:0]                 status_nxt;
  spq_pkg::entry_t            res_r;
  spq_pkg::entry_t            res_nxt;

  // Handshake: accept whenever the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_deq    = (in_tuser[0] == spq_pkg::OP_DEQ);
  assign full      = (count_r == spq_pkg::DEPTH_CNT);
  assign empty     = (count_r == '0);

  // Control broadcast to the cell row
  always_comb begin
    ctrl.enq              = in_acc && !is_deq && !full;
    ctrl.deq              = in_acc && is_deq && !empty;
    ctrl.item.value       = in_tdata[31:0];
    ctrl.item.priority_v  = in_tdata[47:32];
  end

  // Cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_k;

    // slot i is live when it lies below the fill count
    assign cell_occ[i] = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_e = ctrl.item;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (cell_occ[i]),
      .left_keep   (left_k),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Count and result for the accepted request
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_DONE;
    res_nxt    = '0;
    if (is_deq) begin
      if (empty) begin
        status_nxt = spq_pkg::ST_UNDERFLOW;
      end else begin
        count_nxt = count_r - 1'b1;
        res_nxt   = cell_entry[0];
      end
    end else begin
      if (full) begin
        status_nxt = spq_pkg::ST_OVERFLOW;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, count_r, res_r.priority_v, res_r.value};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::DEPTH_CNT)
    else $error("queue count exceeds depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == spq_pkg::ST_OVERFLOW) |-> count_r == spq_pkg::DEPTH_CNT)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == spq_pkg::ST_UNDERFLOW) |-> count_r == '0)
    else $error("underflow reported on a queue that is not empty");

  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.deq |=> out_valid_r && (status_r == spq_pkg::ST_DONE)
                 && (res_r == $past(cell_entry[0])))
    else $error("dequeue did not return the head entry");

endmodule

### verif/sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test: self-checking bench for the priority queue
// Streams enqueue and dequeue requests into the queue with random gaps and
// output stalls. A behavioral copy of the sorted queue predicts each result
// at the moment its request is taken, and every result transaction is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;

  localparam int NUM_RANDOM  = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 400;
  localparam int MAX_REPORTS = 10;

  // Priority patterns for random requests
  typedef enum int {
    PRIO_ANY,       // full 16-bit range
    PRIO_CROWDED,   // few distinct values, many ties
    PRIO_EDGES      // values at both ends of the range
  } prio_mode_t;

  typedef struct packed {
    logic                      op;
    logic [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::PRI_W-1:0] prio;
    logic                      drain;   // hold this request until all results are back
  } request_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::PRI_W-1:0] prio;
    logic [spq_pkg::CNT_W-1:0] fill;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  request_t        pending_requests[$];
  result_t         results_due[$];
  spq_pkg::entry_t held_entries[$];     // model contents, head first

  request_t current_req;
  bit       offering    = 1'b0;
  bit       hold_rx     = 1'b0;
  int       send_wait   = 0;
  int       recv_wait   = 0;
  int       accepted_count = 0;
  int       received_count = 0;
  int       fail_count  = 0;
  int       cycle_count = 0;

  sorted_priority_queue_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones, and whole windows with none
  function automatic int idle_cycles();
    int roll;
    if ((cycle_count / 600) % 4 == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one accepted request to the queue copy and queue its result
  function automatic void apply_request(request_t req);
    spq_pkg::entry_t ent;
    result_t         res;
    int              pos;
    res = '0;
    if (req.op == spq_pkg::OP_ENQ) begin
      if (held_entries.size() >= spq_pkg::QUEUE_DEPTH) begin
        res.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new entry goes behind every held entry of equal or smaller priority
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].priority_v <= req.prio)
          pos++;
        ent.value      = req.value;
        ent.priority_v = req.prio;
        held_entries.insert(pos, ent);
        res.status = spq_pkg::ST_DONE;
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        ent        = held_entries.pop_front();
        res.status = spq_pkg::ST_DONE;
        res.value  = ent.value;
        res.prio   = ent.priority_v;
      end
    end
    res.fill = spq_pkg::CNT_W'(held_entries.size());
    results_due.push_back(res);
  endfunction

  function automatic request_t make_request(logic op, logic [spq_pkg::VAL_W-1:0] value,
                                            logic [spq_pkg::PRI_W-1:0] prio,
                                            logic drain);
    request_t req;
    req.op    = op;
    req.value = value;
    req.prio  = prio;
    req.drain = drain;
    return req;
  endfunction

  function automatic request_t random_request(int enq_pct, prio_mode_t mode,
                                              logic drain);
    logic [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::PRI_W-1:0] prio;
    logic                      op;
    op    = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
    value = $urandom();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'h0000_0000;
        default: value = 32'hFFFF_FFFF;
      endcase
    end
    case (mode)
      PRIO_CROWDED: prio = spq_pkg::PRI_W'($urandom_range(0, 7));
      PRIO_EDGES: begin
        case ($urandom_range(0, 3))
          0: prio = 16'h0000;
          1: prio = 16'h0001;
          2: prio = 16'hFFFE;
          default: prio = 16'hFFFF;
        endcase
      end
      default: prio = spq_pkg::PRI_W'($urandom());
    endcase
    return make_request(op, value, prio, drain);
  endfunction

  // Request driver: offers queued requests, random gaps between them
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(current_req);
        accepted_count++;
        send_wait = idle_cycles();
        offering  = 1'b0;
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].drain || results_due.size() == 0)) begin
          current_req = pending_requests.pop_front();
          in_tdata    <= {current_req.prio, current_req.value};
          in_tuser    <= current_req.op;
          offering    = 1'b1;
        end
      end
      in_tvalid <= offering;
    end
  end

  // Result monitor: random back-pressure, checks every result transaction
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.value  = out_tdata[31:0];
        got.prio   = out_tdata[47:32];
        got.fill   = out_tdata[52:48];
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: unexpected transaction status %0d value %h prio %h fill %0d",
                     received_count, got.status, got.value, got.prio, got.fill);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.prio !== want.prio || got.fill !== want.fill ||
              out_tdata[55:53] !== 3'b000) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $write("result %0d: expected status %0d value %h prio %h fill %0d, ",
                     received_count, want.status, want.value, want.prio, want.fill);
              $display("got status %0d value %h prio %h fill %0d pad %b",
                       got.status, got.value, got.prio, got.fill, out_tdata[55:53]);
            end
          end
        end
        received_count++;
        recv_wait = idle_cycles();
      end
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-offs so the queue backs up and stalls its input
  initial begin : rx_hold_off
    while (accepted_count < 300) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    hold_rx <= 1'b0;
    while (accepted_count < 1200) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (LONG_STALL / 4) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int         added;
    int         phase_len;
    int         enq_pct;
    prio_mode_t mode;

    // Directed: underflow on empty, extreme fields, ties, fill to overflow
    pending_requests.push_back(make_request(spq_pkg::OP_DEQ, 32'hDEAD_BEEF, 16'hA5A5, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h8000_0000, 16'hFFFF, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h7FFF_FFFF, 16'h0000, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h0000_0000, 16'h0000, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h5555_5555, 16'h8000, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'hAAAA_AAAA, 16'h7FFF, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0));
    for (int i = 0; i < 11; i++)
      pending_requests.push_back(make_request(spq_pkg::OP_ENQ, $urandom(),
                                              spq_pkg::PRI_W'(i % 3), 1'b0));
    // queue is full now: two overflows, then dequeue with junk payload
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h1234_5678, 16'h0000, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_ENQ, 32'h8765_4321, 16'hFFFF, 1'b0));
    pending_requests.push_back(make_request(spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));

    // Random phases: fill-heavy, drain-heavy and mixed traffic
    added = 0;
    while (added < NUM_RANDOM) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      mode = prio_mode_t'($urandom_range(0, 2));
      for (int i = 0; i < phase_len; i++) begin
        pending_requests.push_back(random_request(enq_pct, mode,
            (added == 0) || (i == 0 && $urandom_range(0, 4) == 0)));
        added++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
